@@ rtl/msqg_pkg.sv @@
package msqg_pkg;

   // Axis count and field widths fixed by the interface.
   localparam int NUM_AXES            = 5;
   localparam int AXIS_IDX_WIDTH      = 3;
   localparam int COUNT_WIDTH         = 16;
   localparam int POSITION_WIDTH      = 32;
   localparam int TIMER_WIDTH_DEFAULT = 16;

   // Configuration port geometry.
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int REG_INDEX_WIDTH = 2;

   // Register indexes.
   localparam logic [REG_INDEX_WIDTH-1:0] REG_QUAD_MODE      = 2'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_SEGMENT_PERIOD = 2'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_IMAGE_DISABLE  = 2'd2;

   // Reset value of the segment period and the path command threshold.
   localparam logic [COUNT_WIDTH-1:0] SEGMENT_PERIOD_RESET = 16'd16666;
   localparam logic [COUNT_WIDTH-1:0] CMD_MARK             = 16'hFFF0;

   // First axis whose pins the image disable holds, and the last axis index.
   localparam logic [AXIS_IDX_WIDTH-1:0] HELD_FIRST_AXIS = 3'd3;
   localparam logic [AXIS_IDX_WIDTH-1:0] LAST_AXIS       = 3'd4;

   // Quadrature phase codes, written as {A, B}.
   localparam logic [1:0] QUAD_NONE = 2'b00;
   localparam logic [1:0] QUAD_B    = 2'b01;
   localparam logic [1:0] QUAD_A    = 2'b10;

   typedef struct packed {
      logic                   quad_mode;
      logic [COUNT_WIDTH-1:0] segment_period_us;
      logic                   image_pins_disable;
   } cfg_type;

   typedef struct packed {
      logic direction_neg;
      logic phase_a;
      logic phase_b;
   } axis_flags_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_TICK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

@@ rtl/msqg_req_if.sv @@
interface msqg_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   op;
   logic signed [msqg_pkg::COUNT_WIDTH-1:0] count_axis1;
   logic signed [msqg_pkg::COUNT_WIDTH-1:0] count_axis2;
   logic signed [msqg_pkg::COUNT_WIDTH-1:0] count_axis3;
   logic signed [msqg_pkg::COUNT_WIDTH-1:0] count_axis4;
   logic signed [msqg_pkg::COUNT_WIDTH-1:0] count_axis5;

   modport source (
      output valid, op, count_axis1, count_axis2, count_axis3, count_axis4, count_axis5,
      input  ready
   );

   modport sink (
      input  valid, op, count_axis1, count_axis2, count_axis3, count_axis4, count_axis5,
      output ready
   );
endinterface

@@ rtl/msqg_rsp_if.sv @@
interface msqg_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [msqg_pkg::NUM_AXES-1:0]             line_a;
   logic [msqg_pkg::NUM_AXES-1:0]             line_b;
   logic [msqg_pkg::NUM_AXES-1:0]             stepped;
   logic [msqg_pkg::NUM_AXES-1:0]             running;
   logic signed [msqg_pkg::POSITION_WIDTH-1:0] position_axis1;
   logic signed [msqg_pkg::POSITION_WIDTH-1:0] position_axis2;
   logic signed [msqg_pkg::POSITION_WIDTH-1:0] position_axis3;
   logic signed [msqg_pkg::POSITION_WIDTH-1:0] position_axis4;
   logic signed [msqg_pkg::POSITION_WIDTH-1:0] position_axis5;

   modport source (
      output valid, line_a, line_b, stepped, running,
      output position_axis1, position_axis2, position_axis3, position_axis4, position_axis5,
      input  ready
   );

   modport sink (
      input  valid, line_a, line_b, stepped, running,
      input  position_axis1, position_axis2, position_axis3, position_axis4, position_axis5,
      output ready
   );
endinterface

@@ rtl/msqg_csr.sv @@
module msqg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [msqg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [msqg_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [msqg_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output msqg_pkg::cfg_type                   cfg
);

   localparam int IW = msqg_pkg::REG_INDEX_WIDTH;

   msqg_pkg::cfg_type cfg_ff;
   msqg_pkg::cfg_type cfg_in;
   logic [IW-1:0]     reg_index;
   logic              write_en;

   // Registers sit on word addresses.
   assign reg_index  = csr_paddr[IW+1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write decode; addresses past the register list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            msqg_pkg::REG_QUAD_MODE:      cfg_in.quad_mode = csr_pwdata[0];
            msqg_pkg::REG_SEGMENT_PERIOD: cfg_in.segment_period_us =
                                             csr_pwdata[msqg_pkg::COUNT_WIDTH-1:0];
            msqg_pkg::REG_IMAGE_DISABLE:  cfg_in.image_pins_disable = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read decode.
   always_comb begin
      csr_prdata = '0;
      unique case (reg_index)
         msqg_pkg::REG_QUAD_MODE:      csr_prdata[0] = cfg_ff.quad_mode;
         msqg_pkg::REG_SEGMENT_PERIOD: csr_prdata[msqg_pkg::COUNT_WIDTH-1:0] =
                                          cfg_ff.segment_period_us;
         msqg_pkg::REG_IMAGE_DISABLE:  csr_prdata[0] = cfg_ff.image_pins_disable;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quad_mode          <= 1'b0;
         cfg_ff.segment_period_us  <= msqg_pkg::SEGMENT_PERIOD_RESET;
         cfg_ff.image_pins_disable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/msqg_div.sv @@
module msqg_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [msqg_pkg::COUNT_WIDTH-1:0] dividend,
   input  logic [msqg_pkg::COUNT_WIDTH-1:0] divisor,
   output logic                             done,
   output logic [msqg_pkg::COUNT_WIDTH-1:0] quotient
);

   localparam int W  = msqg_pkg::COUNT_WIDTH;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W:0]    rem_shift;
   logic [W:0]    rem_diff;
   logic          quo_bit;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign rem_shift = {rem_ff, dvd_ff[W-1]};
   assign rem_diff  = rem_shift - {1'b0, dsr_ff};
   assign quo_bit   = rem_shift >= {1'b0, dsr_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      bit_cnt_in = bit_cnt_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      dsr_in     = dsr_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         bit_cnt_in = '0;
         rem_in     = '0;
         dvd_in     = dividend;
         dsr_in     = divisor;
         quo_in     = '0;
      end else if (busy_ff) begin
         rem_in     = quo_bit ? rem_diff[W-1:0] : rem_shift[W-1:0];
         dvd_in     = {dvd_ff[W-2:0], 1'b0};
         quo_in     = {quo_ff[W-2:0], quo_bit};
         bit_cnt_in = bit_cnt_ff + 1'b1;
         if (bit_cnt_ff == LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff <= bit_cnt_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      dsr_ff     <= dsr_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/msqg_step_unit.sv @@
module msqg_step_unit #(
   parameter int TIMER_WIDTH = msqg_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic [TIMER_WIDTH-1:0]              elapsed,
   input  logic [TIMER_WIDTH-1:0]              interval,
   input  logic [msqg_pkg::COUNT_WIDTH-1:0]    steps_left,
   input  logic [msqg_pkg::POSITION_WIDTH-1:0] position,
   input  msqg_pkg::axis_flags_type            flags,
   input  logic                                quad_mode,
   input  logic                                held,
   output logic [TIMER_WIDTH-1:0]              elapsed_next,
   output logic [msqg_pkg::COUNT_WIDTH-1:0]    steps_next,
   output logic [msqg_pkg::POSITION_WIDTH-1:0] position_next,
   output msqg_pkg::axis_flags_type            flags_next,
   output logic                                stepped,
   output logic                                driven
);

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   logic                   active;
   logic [TIMER_WIDTH-1:0] elapsed_inc;
   logic                   fire;

   // The timer saturates and the axis fires once it reaches its interval.
   assign active      = steps_left != '0;
   assign elapsed_inc = (elapsed != TIMER_MAX) ? elapsed + 1'b1 : elapsed;
   assign fire        = active && (elapsed_inc >= interval);
   assign stepped     = fire;
   assign driven      = fire && !held;

   always_comb begin
      elapsed_next  = elapsed;
      steps_next    = steps_left;
      position_next = position;
      flags_next    = flags;
      if (active) begin
         elapsed_next = fire ? '0 : elapsed_inc;
      end
      if (fire) begin
         steps_next    = steps_left - 1'b1;
         position_next = flags.direction_neg ? position - 1'b1 : position + 1'b1;
         if (!held) begin
            if (quad_mode) begin
               // Gray-code move, forward or backward.
               case ({flags.phase_a, flags.phase_b})
                  msqg_pkg::QUAD_NONE: begin
                     if (!flags.direction_neg) flags_next.phase_a = 1'b1;
                     else                      flags_next.phase_b = 1'b1;
                  end
                  msqg_pkg::QUAD_B: begin
                     if (!flags.direction_neg) flags_next.phase_b = 1'b0;
                     else                      flags_next.phase_a = 1'b1;
                  end
                  msqg_pkg::QUAD_A: begin
                     if (!flags.direction_neg) flags_next.phase_b = 1'b1;
                     else                      flags_next.phase_a = 1'b0;
                  end
                  default: begin
                     if (!flags.direction_neg) flags_next.phase_a = 1'b0;
                     else                      flags_next.phase_b = 1'b0;
                  end
               endcase
            end else begin
               // Step mode latches the direction and the idle step level.
               flags_next.phase_b = flags.direction_neg;
               flags_next.phase_a = 1'b1;
            end
         end
      end
   end

endmodule

@@ rtl/multi_axis_step_quadrature_generator.sv @@
// Five-axis step/direction or quadrature pulse generator. A load transaction (op = 1)
// takes five signed step counts for one path segment; each nonzero axis gets the
// interval segment_period_us / |count| from one shared restoring divider, one
// quotient bit per cycle; zero counts skip the divider, and a path command skips
// the whole load. A tick transaction (op = 0) runs the axes one at a time through
// a shared step unit. One transaction is in work at a time; the result waits in an
// output register, so the next transaction can be accepted before it is taken.
// Configuration must be written through the APB-style port only while the block
// is idle; the block itself does not enforce this.
module multi_axis_step_quadrature_generator #(
   parameter int TIMER_WIDTH = msqg_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   msqg_req_if.sink                            req_ch,
   msqg_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [msqg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [msqg_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [msqg_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   localparam int AXES = msqg_pkg::NUM_AXES;
   localparam int AIW  = msqg_pkg::AXIS_IDX_WIDTH;
   localparam int CNW  = msqg_pkg::COUNT_WIDTH;
   localparam int PW   = msqg_pkg::POSITION_WIDTH;
   localparam int SAT_WIDTH = (TIMER_WIDTH > CNW) ? TIMER_WIDTH : CNW;

   msqg_pkg::cfg_type   cfg;
   msqg_pkg::state_type state_ff, state_in;
   logic [AIW-1:0]      axis_idx_ff, axis_idx_in;
   logic                div_wait_ff, div_wait_in;

   // Per-axis state.
   logic [TIMER_WIDTH-1:0]   interval_ff [AXES];
   logic [TIMER_WIDTH-1:0]   elapsed_ff  [AXES];
   logic [CNW-1:0]           steps_ff    [AXES];
   logic [PW-1:0]            position_ff [AXES];
   msqg_pkg::axis_flags_type flags_ff    [AXES];
   logic [CNW-1:0]           count_ff    [AXES];
   logic [AXES-1:0]          stepped_ff, stepped_in;
   logic [AXES-1:0]          driven_ff, driven_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic [AXES-1:0] out_line_a_ff, out_line_b_ff, out_stepped_ff, out_running_ff;
   logic [PW-1:0]   out_position_ff [AXES];

   logic                     req_fire;
   logic                     rsp_free;
   logic                     load_out;
   logic                     axis_we;
   logic                     advance;
   logic                     div_start;
   logic                     div_done;
   logic [CNW-1:0]           div_quotient;
   logic [CNW-1:0]           cur_count;
   logic                     cur_neg;
   logic [CNW-1:0]           cur_mag;
   logic [CNW-1:0]           quot_floor;
   logic [SAT_WIDTH-1:0]     quot_wide;
   logic [SAT_WIDTH-1:0]     timer_max_wide;
   logic [SAT_WIDTH-1:0]     quot_sat;
   logic                     held;
   logic [TIMER_WIDTH-1:0]   wr_interval, wr_elapsed;
   logic [CNW-1:0]           wr_steps;
   logic [PW-1:0]            wr_position;
   msqg_pkg::axis_flags_type wr_flags;
   logic [TIMER_WIDTH-1:0]   su_elapsed;
   logic [CNW-1:0]           su_steps;
   logic [PW-1:0]            su_position;
   msqg_pkg::axis_flags_type su_flags;
   logic                     su_stepped, su_driven;
   logic [AXES-1:0]          line_a_now, line_b_now, running_now;

   msqg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshakes.
   assign req_ch.ready = (state_ff == msqg_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Magnitude and direction of the count for the axis in work.
   assign cur_count = count_ff[axis_idx_ff];
   assign cur_neg   = cur_count[CNW-1];
   assign cur_mag   = cur_neg ? ('0 - cur_count) : cur_count;

   msqg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.segment_period_us),
      .divisor  (cur_mag),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // The interval is at least one and saturates at the timer range.
   assign quot_floor     = (div_quotient == '0) ? CNW'(1) : div_quotient;
   assign quot_wide      = SAT_WIDTH'(quot_floor);
   assign timer_max_wide = SAT_WIDTH'({TIMER_WIDTH{1'b1}});
   assign quot_sat       = (quot_wide > timer_max_wide) ? timer_max_wide : quot_wide;

   assign held = cfg.image_pins_disable && (axis_idx_ff >= msqg_pkg::HELD_FIRST_AXIS);

   msqg_step_unit #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_step (
      .elapsed       (elapsed_ff[axis_idx_ff]),
      .interval      (interval_ff[axis_idx_ff]),
      .steps_left    (steps_ff[axis_idx_ff]),
      .position      (position_ff[axis_idx_ff]),
      .flags         (flags_ff[axis_idx_ff]),
      .quad_mode     (cfg.quad_mode),
      .held          (held),
      .elapsed_next  (su_elapsed),
      .steps_next    (su_steps),
      .position_next (su_position),
      .flags_next    (su_flags),
      .stepped       (su_stepped),
      .driven        (su_driven)
   );

   // Sequencer: walks the axes once per load or tick; a path command goes straight to the result.
   always_comb begin
      state_in    = state_ff;
      axis_idx_in = axis_idx_ff;
      div_wait_in = div_wait_ff;
      div_start   = 1'b0;
      axis_we     = 1'b0;
      advance     = 1'b0;
      load_out    = 1'b0;
      wr_interval = interval_ff[axis_idx_ff];
      wr_elapsed  = '0;
      wr_steps    = cur_mag;
      wr_position = position_ff[axis_idx_ff];
      wr_flags    = flags_ff[axis_idx_ff];
      stepped_in  = stepped_ff;
      driven_in   = driven_ff;

      unique case (state_ff)
         msqg_pkg::ST_IDLE: begin
            if (req_fire) begin
               axis_idx_in = '0;
               stepped_in  = '0;
               driven_in   = '0;
               if (!req_ch.op) begin
                  state_in = msqg_pkg::ST_TICK;
               end else if ($unsigned(req_ch.count_axis1) < msqg_pkg::CMD_MARK) begin
                  state_in = msqg_pkg::ST_LOAD;
               end else begin
                  state_in = msqg_pkg::ST_DONE;
               end
            end
         end
         msqg_pkg::ST_LOAD: begin
            wr_flags.direction_neg = cur_neg;
            if (!div_wait_ff) begin
               if (cur_mag == '0) begin
                  // A zero count stops the axis at once.
                  wr_interval = '0;
                  axis_we     = 1'b1;
                  advance     = 1'b1;
               end else begin
                  div_start   = 1'b1;
                  div_wait_in = 1'b1;
               end
            end else if (div_done) begin
               wr_interval = quot_sat[TIMER_WIDTH-1:0];
               axis_we     = 1'b1;
               advance     = 1'b1;
               div_wait_in = 1'b0;
            end
         end
         msqg_pkg::ST_TICK: begin
            wr_elapsed  = su_elapsed;
            wr_steps    = su_steps;
            wr_position = su_position;
            wr_flags    = su_flags;
            axis_we     = 1'b1;
            advance     = 1'b1;
            if (su_stepped) stepped_in[axis_idx_ff] = 1'b1;
            if (su_driven)  driven_in[axis_idx_ff]  = 1'b1;
         end
         msqg_pkg::ST_DONE: begin
            if (rsp_free) begin
               load_out = 1'b1;
               state_in = msqg_pkg::ST_IDLE;
            end
         end
         default: state_in = msqg_pkg::ST_IDLE;
      endcase

      if (advance) begin
         if (axis_idx_ff == msqg_pkg::LAST_AXIS) begin
            state_in = msqg_pkg::ST_DONE;
         end else begin
            axis_idx_in = axis_idx_ff + 1'b1;
         end
      end
   end

   // Line levels and running flags from the current state.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         line_a_now[i]  = cfg.quad_mode ? flags_ff[i].phase_a : !driven_ff[i];
         line_b_now[i]  = flags_ff[i].phase_b;
         running_now[i] = steps_ff[i] != '0;
      end
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // Control state and per-axis state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msqg_pkg::ST_IDLE;
         axis_idx_ff  <= '0;
         div_wait_ff  <= 1'b0;
         stepped_ff   <= '0;
         driven_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            interval_ff[i] <= '0;
            elapsed_ff[i]  <= '0;
            steps_ff[i]    <= '0;
            position_ff[i] <= '0;
            flags_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_idx_ff  <= axis_idx_in;
         div_wait_ff  <= div_wait_in;
         stepped_ff   <= stepped_in;
         driven_ff    <= driven_in;
         rsp_valid_ff <= rsp_valid_in;
         if (axis_we) begin
            interval_ff[axis_idx_ff] <= wr_interval;
            elapsed_ff[axis_idx_ff]  <= wr_elapsed;
            steps_ff[axis_idx_ff]    <= wr_steps;
            position_ff[axis_idx_ff] <= wr_position;
            flags_ff[axis_idx_ff]    <= wr_flags;
         end
      end
   end

   // Counts of the accepted transaction and the result payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         count_ff[0] <= req_ch.count_axis1;
         count_ff[1] <= req_ch.count_axis2;
         count_ff[2] <= req_ch.count_axis3;
         count_ff[3] <= req_ch.count_axis4;
         count_ff[4] <= req_ch.count_axis5;
      end
      if (load_out) begin
         out_line_a_ff  <= line_a_now;
         out_line_b_ff  <= line_b_now;
         out_stepped_ff <= stepped_ff;
         out_running_ff <= running_now;
         for (int i = 0; i < AXES; i++) begin
            out_position_ff[i] <= position_ff[i];
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.line_a         = out_line_a_ff;
   assign rsp_ch.line_b         = out_line_b_ff;
   assign rsp_ch.stepped        = out_stepped_ff;
   assign rsp_ch.running        = out_running_ff;
   assign rsp_ch.position_axis1 = out_position_ff[0];
   assign rsp_ch.position_axis2 = out_position_ff[1];
   assign rsp_ch.position_axis3 = out_position_ff[2];
   assign rsp_ch.position_axis4 = out_position_ff[3];
   assign rsp_ch.position_axis5 = out_position_ff[4];

   // The divider only finishes while a load waits for it.
   a_div_done_in_load: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == msqg_pkg::ST_LOAD && div_wait_ff))
      else $error("divider finished outside a load");

   // An accepted transaction keeps the input closed on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("input ready right after acceptance");

   // The axis walk never leaves the axis range.
   a_axis_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msqg_pkg::ST_TICK || state_ff == msqg_pkg::ST_LOAD)
         |-> (axis_idx_ff <= msqg_pkg::LAST_AXIS))
      else $error("axis index out of range");

   // A finished transaction reaches the output register once it is free.
   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msqg_pkg::ST_DONE && rsp_free) |=> (rsp_valid_ff && req_ch.ready))
      else $error("result not posted");

endmodule
